FILE: hdl/chol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chol_pkg
// shared constants, types and helpers of the cholesky factorizer
// ----------------------------------------------------------------------------
package chol_pkg;

	localparam int MAX_DIM_DEF   = 8;
	localparam int FRAC_BITS_DEF = 24;
	localparam int DATA_W        = 32;
	localparam int ACC_W         = 64;
	localparam int CFG_W         = 4;
	localparam int IDX_OUT_W     = 3;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RD_A,
		ST_LD_A,
		ST_MAC_RD,
		ST_MAC_MUL,
		ST_MAC_ACC,
		ST_FINISH,
		ST_SQRT,
		ST_DIV,
		ST_WRITE,
		ST_OUT
	} state_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		begin
			hi = ACC_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
			lo = ACC_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}));
			if (v > hi) begin
				sat32 = hi[DATA_W-1:0];
			end else if (v < lo) begin
				sat32 = lo[DATA_W-1:0];
			end else begin
				sat32 = v[DATA_W-1:0];
			end
		end
	endfunction

endpackage
`default_nettype wire

FILE: hdl/cholesky_factorizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cholesky_factorizer
// loads the lower triangle of a symmetric matrix and emits its cholesky
// factor row by row, signed fixed point
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   ------------------------------------------
//  input     in_valid / in_ready   cov_value
//  output    out_valid / out_ready factor_value, row_index, col_index,
//                                  not_positive, last_out
//  config    cfg_wr_en             cfg_wr_data (active_dim)
//
//  loading takes one request per cycle; the last request starts the factor
//  element (i,j) reads its operands, then runs j multiply-accumulate terms
//  (one shared multiplier, read-multiply-subtract per term), then the square
//  root on the diagonal or the divider off it, and is then written back and
//  presented as the result
//  reset clears the state machine, the load count and the error flag;
//  the stores hold no reset and are only read where written in the current load
//  a stalled output holds the sequencer; no request is taken during the factor

module cholesky_factorizer #(
	parameter int MAX_DIM   = chol_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = chol_pkg::FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_wr_en,
	input  wire logic [chol_pkg::CFG_W-1:0]         cfg_wr_data,
	// input requests
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [chol_pkg::DATA_W-1:0] cov_value,
	// output requests
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [chol_pkg::DATA_W-1:0]      factor_value,
	output logic [chol_pkg::IDX_OUT_W-1:0]          row_index,
	output logic [chol_pkg::IDX_OUT_W-1:0]          col_index,
	output logic                                    not_positive,
	output logic                                    last_out
);

	localparam int DW    = chol_pkg::DATA_W;
	localparam int AC_W  = chol_pkg::ACC_W;
	localparam int TRI   = MAX_DIM * (MAX_DIM + 1) / 2;
	localparam int AW    = $clog2(TRI);
	localparam int LW    = $clog2(TRI + 1);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int NUM_W = DW + FRAC_BITS;
	localparam logic signed [AC_W-1:0] HALF = AC_W'(64'sd1 <<< (FRAC_BITS - 1));

	chol_pkg::state_t state_q, state_d;

	// configuration and load bookkeeping
	logic [chol_pkg::CFG_W-1:0] active_dim_q;
	logic [LW-1:0]              load_cnt_q;
	logic [DIM_W-1:0]           eff_dim;
	logic [2*DIM_W-1:0]         tri_prod;
	logic [LW-1:0]              total;
	logic [LW-1:0]              ld_idx;

	// sequencer registers
	logic [IDX_W-1:0]           i_q, j_q, k_q;
	logic [AW-1:0]              base_i_q, base_j_q;
	logic signed [AC_W-1:0]     acc_q;
	logic signed [DW-1:0]       d_q;
	logic signed [DW-1:0]       val_q;
	logic signed [AC_W-1:0]     prod_s1;
	logic                       err_q;

	// output register
	logic signed [DW-1:0]       factor_q;
	logic [chol_pkg::IDX_OUT_W-1:0] row_q, col_q;
	logic                       npos_q, last_q;

	// memories
	logic [DW-1:0]              cov_rd, fa_rd, fb_rd;
	logic [AW-1:0]              cov_raddr, fa_raddr, fb_raddr, fac_waddr;
	logic                       cov_we, fac_we;

	// arithmetic
	logic signed [AC_W-1:0]     rnd;
	logic signed [DW-1:0]       r_fin;
	logic                       diag, last_elem, last_load;
	logic                       sq_start, sq_done, dv_start, dv_done;
	logic [DW-1:0]              sq_root;
	logic signed [DW-1:0]       dv_quot;

	// effective dimension, zero acts as one, clamped at the maximum
	always_comb begin
		if (active_dim_q == '0) begin
			eff_dim = DIM_W'(1);
		end else if (active_dim_q > chol_pkg::CFG_W'(MAX_DIM)) begin
			eff_dim = DIM_W'(MAX_DIM);
		end else begin
			eff_dim = DIM_W'(active_dim_q);
		end
	end

	assign tri_prod  = (2*DIM_W)'(eff_dim) * ((2*DIM_W)'(eff_dim) + 1'b1);
	assign total     = LW'(tri_prod >> 1);
	assign ld_idx    = (load_cnt_q >= total) ? '0 : load_cnt_q;
	assign last_load = (ld_idx + 1'b1 == total);

	assign diag      = (i_q == j_q);
	assign last_elem = diag && (DIM_W'(i_q) == eff_dim - 1'b1);
	assign rnd       = (prod_s1 + HALF) >>> FRAC_BITS;
	assign r_fin     = chol_pkg::sat32(acc_q);

	// memory addressing
	assign cov_we    = in_valid && in_ready;
	assign cov_raddr = AW'(base_i_q + AW'(j_q));
	assign fa_raddr  = (state_q == chol_pkg::ST_RD_A) ? AW'(base_j_q + AW'(j_q))
	                                                  : AW'(base_i_q + AW'(k_q));
	assign fb_raddr  = AW'(base_j_q + AW'(k_q));
	assign fac_waddr = AW'(base_i_q + AW'(j_q));

	chol_ram #(.DEPTH(TRI), .WIDTH(DW), .AW(AW)) u_cov_ram (
		.clk     (clk),
		.wr_en   (cov_we),
		.wr_addr (ld_idx[AW-1:0]),
		.wr_data (cov_value),
		.rd_addr (cov_raddr),
		.rd_data (cov_rd)
	);

	// factor store kept twice so two terms can be read per cycle
	chol_ram #(.DEPTH(TRI), .WIDTH(DW), .AW(AW)) u_fac_ram_a (
		.clk     (clk),
		.wr_en   (fac_we),
		.wr_addr (fac_waddr),
		.wr_data (val_q),
		.rd_addr (fa_raddr),
		.rd_data (fa_rd)
	);

	chol_ram #(.DEPTH(TRI), .WIDTH(DW), .AW(AW)) u_fac_ram_b (
		.clk     (clk),
		.wr_en   (fac_we),
		.wr_addr (fac_waddr),
		.wr_data (val_q),
		.rd_addr (fb_raddr),
		.rd_data (fb_rd)
	);

	chol_sqrt #(.ROOT_W(DW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ((2*DW)'($unsigned(r_fin)) << FRAC_BITS),
		.done     (sq_done),
		.root     (sq_root)
	);

	chol_div #(.NUM_W(NUM_W), .DEN_W(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    ({r_fin, {FRAC_BITS{1'b0}}}),
		.den    (d_q),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chol_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		fac_we    = 1'b0;
		sq_start  = 1'b0;
		dv_start  = 1'b0;
		unique case (state_q)
			chol_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid && last_load) begin
					state_d = chol_pkg::ST_RD_A;
				end
			end
			chol_pkg::ST_RD_A: begin
				state_d = chol_pkg::ST_LD_A;
			end
			chol_pkg::ST_LD_A: begin
				state_d = (j_q == '0) ? chol_pkg::ST_FINISH : chol_pkg::ST_MAC_RD;
			end
			chol_pkg::ST_MAC_RD: begin
				state_d = chol_pkg::ST_MAC_MUL;
			end
			chol_pkg::ST_MAC_MUL: begin
				state_d = chol_pkg::ST_MAC_ACC;
			end
			chol_pkg::ST_MAC_ACC: begin
				state_d = (k_q + 1'b1 == j_q) ? chol_pkg::ST_FINISH : chol_pkg::ST_MAC_RD;
			end
			chol_pkg::ST_FINISH: begin
				if (diag) begin
					if (r_fin > 0) begin
						sq_start = 1'b1;
						state_d  = chol_pkg::ST_SQRT;
					end else begin
						state_d = chol_pkg::ST_WRITE;
					end
				end else begin
					if (d_q != '0) begin
						dv_start = 1'b1;
						state_d  = chol_pkg::ST_DIV;
					end else begin
						state_d = chol_pkg::ST_WRITE;
					end
				end
			end
			chol_pkg::ST_SQRT: begin
				if (sq_done) begin
					state_d = chol_pkg::ST_WRITE;
				end
			end
			chol_pkg::ST_DIV: begin
				if (dv_done) begin
					state_d = chol_pkg::ST_WRITE;
				end
			end
			chol_pkg::ST_WRITE: begin
				fac_we  = 1'b1;
				state_d = chol_pkg::ST_OUT;
			end
			chol_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = last_elem ? chol_pkg::ST_LOAD : chol_pkg::ST_RD_A;
				end
			end
			default: begin
				state_d = chol_pkg::ST_LOAD;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_dim_q <= chol_pkg::CFG_W'(8);
			load_cnt_q   <= '0;
			err_q        <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			base_i_q     <= '0;
			base_j_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				active_dim_q <= cfg_wr_data;
				load_cnt_q   <= '0;
			end else if (cov_we) begin
				load_cnt_q <= last_load ? '0 : ld_idx + 1'b1;
			end
			if (cov_we && last_load) begin
				// new factorization
				err_q    <= 1'b0;
				i_q      <= '0;
				j_q      <= '0;
				base_i_q <= '0;
				base_j_q <= '0;
			end
			if (state_q == chol_pkg::ST_LD_A) begin
				k_q <= '0;
			end
			if (state_q == chol_pkg::ST_MAC_ACC) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == chol_pkg::ST_FINISH) begin
				if ((diag && !(r_fin > 0)) || (!diag && d_q == '0)) begin
					err_q <= 1'b1;
				end
			end
			if (state_q == chol_pkg::ST_OUT && out_ready && !last_elem) begin
				if (diag) begin
					i_q      <= i_q + 1'b1;
					j_q      <= '0;
					base_i_q <= AW'(base_i_q + AW'(i_q) + 1'b1);
					base_j_q <= '0;
				end else begin
					j_q      <= j_q + 1'b1;
					base_j_q <= AW'(base_j_q + AW'(j_q) + 1'b1);
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			chol_pkg::ST_LD_A: begin
				acc_q <= AC_W'($signed(cov_rd));
				d_q   <= $signed(fa_rd);
			end
			chol_pkg::ST_MAC_MUL: begin
				prod_s1 <= $signed(fa_rd) * $signed(fb_rd);
			end
			chol_pkg::ST_MAC_ACC: begin
				acc_q <= acc_q - rnd;
			end
			chol_pkg::ST_FINISH: begin
				val_q <= '0;
			end
			chol_pkg::ST_SQRT: begin
				val_q <= $signed(sq_root);
			end
			chol_pkg::ST_DIV: begin
				val_q <= dv_quot;
			end
			chol_pkg::ST_WRITE: begin
				factor_q <= val_q;
				row_q    <= chol_pkg::IDX_OUT_W'(i_q);
				col_q    <= chol_pkg::IDX_OUT_W'(j_q);
				npos_q   <= err_q;
				last_q   <= last_elem;
			end
			default: begin
			end
		endcase
	end

	assign factor_value = factor_q;
	assign row_index    = row_q;
	assign col_index    = col_q;
	assign not_positive = npos_q;
	assign last_out     = last_q;

	// checks
	a_no_load_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request taken while a result is pending");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(sq_start && dv_start))
		else $error("square root and divider started together");

	a_last_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_out) |=> in_ready)
		else $error("sequencer did not return to loading after last element");

	a_col_not_above_row: assert property (@(posedge clk) disable iff (!arst_n)
		fac_we |-> (j_q <= i_q))
		else $error("factor written above the diagonal");

	a_write_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		fac_we |=> out_valid)
		else $error("factor write not followed by a result");

endmodule
`default_nettype wire

FILE: hdl/chol_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chol_ram
// simple dual-port synchronous ram, one write and one registered read
// ----------------------------------------------------------------------------
module chol_ram #(
	parameter int DEPTH = 36,
	parameter int WIDTH = 32,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

FILE: hdl/chol_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chol_sqrt
// bit-serial integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module chol_sqrt #(
	parameter int ROOT_W = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [2*ROOT_W-1:0]   radicand,
	output logic                       done,
	output logic      [ROOT_W-1:0]     root
);

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [2*ROOT_W-1:0] x_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;

	logic [REM_W+1:0]    rem_sh;
	logic [REM_W+1:0]    trial;
	logic                fits;

	assign rem_sh = {rem_q, x_q[2*ROOT_W-1 -: 2]};
	assign trial  = (REM_W+2)'({root_q, 2'b01});
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(ROOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			x_q <= {x_q[2*ROOT_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_W'(rem_sh - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

FILE: hdl/chol_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chol_div
// restoring signed divider, truncating, saturated to the data width
// ----------------------------------------------------------------------------
module chol_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [NUM_W-1:0]  num,
	input  wire logic signed [DEN_W-1:0]  den,
	output logic                          done,
	output logic signed      [DEN_W-1:0]  quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DEN_W:0]   rem_sh;
	logic             fits;
	logic [NUM_W:0]   max_pos;
	logic [NUM_W:0]   max_neg;

	assign rem_sh  = {rem_q, q_q[NUM_W-1]};
	assign fits    = (rem_sh >= {1'b0, den_q});
	assign max_pos = (NUM_W+1)'({1'b0, {(DEN_W-1){1'b1}}});
	assign max_neg = (NUM_W+1)'({1'b1, {(DEN_W-1){1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			den_q <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
			neg_q <= num[NUM_W-1] ^ den[DEN_W-1];
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			q_q <= {q_q[NUM_W-2:0], fits};
			if (fits) begin
				rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
			end else begin
				rem_q <= rem_sh[DEN_W-1:0];
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			if ({1'b0, q_q} > max_neg) begin
				quot = {1'b1, {(DEN_W-1){1'b0}}};
			end else begin
				quot = DEN_W'(-q_q);
			end
		end else begin
			if ({1'b0, q_q} > max_pos) begin
				quot = {1'b0, {(DEN_W-1){1'b1}}};
			end else begin
				quot = q_q[DEN_W-1:0];
			end
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

FILE: dv/cholesky_factorizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cholesky_factorizer_checker
// watches the request channels of the factorizer, keeps a fixed-point model
// of the load and factor, and compares every emitted factor element
// ----------------------------------------------------------------------------
module cholesky_factorizer_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [chol_pkg::CFG_W-1:0]             cfg_wr_data,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic signed [chol_pkg::DATA_W-1:0]     cov_value,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic signed [chol_pkg::DATA_W-1:0]     factor_value,
	input  logic [chol_pkg::IDX_OUT_W-1:0]         row_index,
	input  logic [chol_pkg::IDX_OUT_W-1:0]         col_index,
	input  logic                                   not_positive,
	input  logic                                   last_out,
	output int                                     fail_count,
	output int                                     pending_count
);

	localparam int MAXD = chol_pkg::MAX_DIM_DEF;
	localparam int FB   = chol_pkg::FRAC_BITS_DEF;
	localparam int TRI  = MAXD * (MAXD + 1) / 2;

	typedef struct packed {
		logic signed [chol_pkg::DATA_W-1:0]   value;
		logic [chol_pkg::IDX_OUT_W-1:0]       row;
		logic [chol_pkg::IDX_OUT_W-1:0]       col;
		logic                                 npd;
		logic                                 last;
	} factor_elem_t;

	logic [chol_pkg::CFG_W-1:0]           dim_reg;
	logic signed [chol_pkg::DATA_W-1:0]   cov_mem [TRI];
	logic signed [chol_pkg::DATA_W-1:0]   l_mem [TRI];
	int                                   loaded;
	// ring of expected elements, at most one factor outstanding
	factor_elem_t                         exp_mem [TRI];
	int                                   exp_wr;
	int                                   exp_rd;

	function automatic int tri_at(int r, int c);
		return r * (r + 1) / 2 + c;
	endfunction

	function automatic int dim_in_use();
		int d;
		d = dim_reg;
		if (d < 1) d = 1;
		if (d > MAXD) d = MAXD;
		return d;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_root(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// banachiewicz order; all elements emitted at once after the last load
	task automatic factorize();
		int n, cnt;
		longint acc, val, p, d;
		logic err;
		factor_elem_t e;
		n = dim_in_use();
		cnt = 0;
		err = 1'b0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j <= i; j++) begin
				acc = cov_mem[tri_at(i, j)];
				for (int k = 0; k < j; k++) begin
					p = longint'(l_mem[tri_at(i, k)]) * longint'(l_mem[tri_at(j, k)]);
					p = p + (64'sd1 <<< (FB - 1));
					acc -= (p >>> FB);
				end
				acc = clamp32(acc);
				if (i == j) begin
					if (acc <= 0) begin
						val = 0;
						err = 1'b1;
					end else begin
						val = longint'(int_root(longint'(acc) << FB));
					end
				end else begin
					d = l_mem[tri_at(j, j)];
					if (d == 0) begin
						val = 0;
						err = 1'b1;
					end else begin
						val = clamp32((acc * (64'sd1 <<< FB)) / d);
					end
				end
				l_mem[tri_at(i, j)] = val[chol_pkg::DATA_W-1:0];
				cnt++;
				e.value = val[chol_pkg::DATA_W-1:0];
				e.row   = i[chol_pkg::IDX_OUT_W-1:0];
				e.col   = j[chol_pkg::IDX_OUT_W-1:0];
				e.npd   = err;
				e.last  = (cnt == n * (n + 1) / 2);
				exp_mem[exp_wr % TRI] = e;
				exp_wr++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		factor_elem_t got, exp_e;
		int total;
		if (!arst_n) begin
			dim_reg = 4'd8;
			loaded = 0;
			fail_count = 0;
			exp_wr = 0;
			exp_rd = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{factor_value, row_index, col_index, not_positive, last_out};
				if (exp_wr == exp_rd) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected factor element %p", got);
				end else begin
					exp_e = exp_mem[exp_rd % TRI];
					exp_rd++;
					if (got !== exp_e) begin
						fail_count++;
						if (fail_count <= 10)
							$display("factor mismatch expected %p actual %p", exp_e, got);
					end
				end
			end
			if (cfg_wr_en) begin
				dim_reg = cfg_wr_data;
				loaded = 0;
			end
			if (in_valid && in_ready) begin
				total = dim_in_use() * (dim_in_use() + 1) / 2;
				if (loaded >= total) loaded = 0;
				cov_mem[loaded] = cov_value;
				loaded++;
				if (loaded >= total) begin
					loaded = 0;
					factorize();
				end
			end
		end
		pending_count = exp_wr - exp_rd;
	end
endmodule

FILE: dv/cholesky_factorizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cholesky_factorizer_tb
// drives covariance loads at several dimensions, mostly positive definite
// matrices with random content plus degenerate and raw random ones, and
// leaves checking to the companion checker
// ----------------------------------------------------------------------------
module cholesky_factorizer_tb;

	localparam int STALL_LIMIT = 20000;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_wr_en;
	logic [chol_pkg::CFG_W-1:0]         cfg_wr_data;
	logic                               in_valid;
	logic                               in_ready;
	logic signed [chol_pkg::DATA_W-1:0] cov_value;
	logic                               out_valid;
	logic                               out_ready;
	logic signed [chol_pkg::DATA_W-1:0] factor_value;
	logic [chol_pkg::IDX_OUT_W-1:0]     row_index;
	logic [chol_pkg::IDX_OUT_W-1:0]     col_index;
	logic                               not_positive;
	logic                               last_out;
	int                                 fail_count;
	int                                 pending_count;
	int                                 idle_cycles;
	int                                 item_count;
	bit                                 rx_quiet;

	cholesky_factorizer DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .cov_value(cov_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.factor_value(factor_value), .row_index(row_index), .col_index(col_index),
		.not_positive(not_positive), .last_out(last_out)
	);

	cholesky_factorizer_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .cov_value(cov_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.factor_value(factor_value), .row_index(row_index), .col_index(col_index),
		.not_positive(not_positive), .last_out(last_out),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// sends one covariance request after a random gap; returns at the
	// accepting edge with valid still high, the next negedge drops or reuses it
	task automatic send_cov(input logic signed [chol_pkg::DATA_W-1:0] v);
		int gap;
		gap = (item_count % 9 == 8) ? 0 : $urandom_range(0, 11);
		if (rx_quiet) gap = 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		cov_value <= v;
		do @(posedge clk); while (!in_ready);
		item_count++;
	endtask

	// ends a burst of requests at the next falling edge
	task automatic stop_cov();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// loads a diagonally dominant, hence positive definite, matrix
	task automatic send_pd(input int n, input int scale);
		for (int i = 0; i < n; i++)
			for (int j = 0; j <= i; j++)
				if (i == j) send_cov(32'sd1 << scale);
				else send_cov($signed($urandom_range(0, (1 << scale) / (2 * n))) *
					(($urandom_range(0, 1) != 0) ? 1 : -1));
	endtask

	task automatic send_raw(input int n);
		for (int k = 0; k < n * (n + 1) / 2; k++) send_cov($urandom);
	endtask

	// idle wait before a register write; the factor may still run
	task automatic drain();
		stop_cov();
		while (pending_count != 0) @(negedge clk);
		repeat (3000) @(negedge clk);
	endtask

	task automatic set_dim(input logic [chol_pkg::CFG_W-1:0] d);
		stop_cov();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= d;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// receiver stalls drawn per element, with runs of no stall
	initial begin
		int wait_n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			wait_n = rx_quiet ? 0 : $urandom_range(0, 11);
			if (wait_n != 0) begin
				out_ready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// watchdog on cycles without any accepted request
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("cholesky_factorizer test failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int d;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		cov_value   = '0;
		idle_cycles = 0;
		item_count  = 0;
		rx_quiet    = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: dimension one at field extremes, zero and negative radicand
		set_dim(4'd1);
		send_cov(32'sh7fffffff);
		send_cov(32'sh80000000);
		send_cov(32'sd0);
		send_cov(32'sh01000000);
		send_cov(32'shffffffff);
		drain();
		// dimension two: zero divisor, saturating quotient, positive definite
		set_dim(4'd2);
		send_cov(32'sd0); send_cov(32'sh01000000); send_cov(32'sh01000000);
		send_cov(32'sd1); send_cov(32'sh7fffffff); send_cov(32'sh01000000);
		send_cov(32'sh04000000); send_cov(32'sh01000000); send_cov(32'sh02000000);
		drain();
		// dimension zero acts as one, above range acts as full size
		set_dim(4'd0);
		send_cov(32'sh02000000);
		drain();
		set_dim(4'd15);
		rx_quiet = 1;
		send_pd(8, 24);
		rx_quiet = 0;
		drain();
		// partial load discarded by a register write
		set_dim(4'd3);
		send_cov(32'sh55555555);
		send_cov(32'shaaaaaaaa);
		set_dim(4'd3);
		send_pd(3, 24);
		drain();

		// random: mostly positive definite loads at small sizes
		while (item_count < 230) begin
			d = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 4);
			set_dim(d[chol_pkg::CFG_W-1:0]);
			for (int r = 0; r < 3 && item_count < 230; r++)
				case ($urandom_range(0, 5))
					0: send_raw(d);
					1: send_pd(d, $urandom_range(16, 28));
					default: send_pd(d, 24);
				endcase
			drain();
		end

		drain();
		if (fail_count == 0)
			$display("cholesky_factorizer test passed");
		else
			$display("cholesky_factorizer test failed");
		$finish;
	end
endmodule
